// File: hdl/upwind_advection_stencil_2d_macros.svh
// Assertion macros shared by the stencil RTL.
// Full checks in simulation, empty bodies for synthesis.
`ifndef UPWIND_ADVECTION_STENCIL_2D_MACROS_SVH
`define UPWIND_ADVECTION_STENCIL_2D_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define UAS_ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication
`define UAS_ASSERT_NXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m: next-cycle check failed");

`else

`define UAS_ASSERT_IMP(name, clk, rst_n, pre, post)
`define UAS_ASSERT_NXT(name, clk, rst_n, pre, post)

`endif

`endif

// File: hdl/uas_pkg.sv
package uas_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int COORD_BITS_DEF = 12;

    localparam int COORD_W    = 12;
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_DATA_W-1:0] INV_SPACING_RESET = 32'd65536;
    localparam logic [DATA_W-1:0]     SAT_MAX           = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0]     SAT_MIN           = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INV_SPACING_X = 2'd0,
        CFG_INV_SPACING_Y = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [COORD_W-1:0]       col;
        logic [COORD_W-1:0]       row;
        logic signed [DATA_W-1:0] u_center;
        logic signed [DATA_W-1:0] u_east;
        logic signed [DATA_W-1:0] u_west;
        logic signed [DATA_W-1:0] u_north;
        logic signed [DATA_W-1:0] u_south;
        logic signed [DATA_W-1:0] v_center;
        logic signed [DATA_W-1:0] v_east;
        logic signed [DATA_W-1:0] v_west;
        logic signed [DATA_W-1:0] v_north;
        logic signed [DATA_W-1:0] v_south;
    } stencil_t;

    // face velocities and the upwind value picked for each of the 8 flux products
    typedef struct packed {
        logic [COORD_W-1:0]       col;
        logic [COORD_W-1:0]       row;
        logic signed [DATA_W-1:0] fe;
        logic signed [DATA_W-1:0] fw;
        logic signed [DATA_W-1:0] fn;
        logic signed [DATA_W-1:0] fs;
        logic signed [DATA_W-1:0] ux_e;
        logic signed [DATA_W-1:0] ux_w;
        logic signed [DATA_W-1:0] uy_n;
        logic signed [DATA_W-1:0] uy_s;
        logic signed [DATA_W-1:0] vx_e;
        logic signed [DATA_W-1:0] vx_w;
        logic signed [DATA_W-1:0] vy_n;
        logic signed [DATA_W-1:0] vy_s;
    } face_t;

    // flux differences, Q.2F, exact in 64 bits
    typedef struct packed {
        logic [COORD_W-1:0]       col;
        logic [COORD_W-1:0]       row;
        logic signed [PROD_W-1:0] dux;
        logic signed [PROD_W-1:0] duy;
        logic signed [PROD_W-1:0] dvx;
        logic signed [PROD_W-1:0] dvy;
    } flux_t;

    typedef struct packed {
        logic [COORD_W-1:0]       col;
        logic [COORD_W-1:0]       row;
        logic signed [DATA_W-1:0] adv_u;
        logic signed [DATA_W-1:0] adv_v;
    } result_t;

endpackage

// File: hdl/uas_if.sv
interface uas_stencil_if;
    logic                               valid;
    logic                               ready;
    logic [uas_pkg::COORD_W-1:0]        cell_col;
    logic [uas_pkg::COORD_W-1:0]        cell_row;
    logic signed [uas_pkg::DATA_W-1:0]  u_center;
    logic signed [uas_pkg::DATA_W-1:0]  u_east;
    logic signed [uas_pkg::DATA_W-1:0]  u_west;
    logic signed [uas_pkg::DATA_W-1:0]  u_north;
    logic signed [uas_pkg::DATA_W-1:0]  u_south;
    logic signed [uas_pkg::DATA_W-1:0]  v_center;
    logic signed [uas_pkg::DATA_W-1:0]  v_east;
    logic signed [uas_pkg::DATA_W-1:0]  v_west;
    logic signed [uas_pkg::DATA_W-1:0]  v_north;
    logic signed [uas_pkg::DATA_W-1:0]  v_south;

    modport source (
        output valid, cell_col, cell_row,
        output u_center, u_east, u_west, u_north, u_south,
        output v_center, v_east, v_west, v_north, v_south,
        input  ready
    );
    modport sink (
        input  valid, cell_col, cell_row,
        input  u_center, u_east, u_west, u_north, u_south,
        input  v_center, v_east, v_west, v_north, v_south,
        output ready
    );
endinterface

interface uas_result_if;
    logic                               valid;
    logic                               ready;
    logic [uas_pkg::COORD_W-1:0]        out_col;
    logic [uas_pkg::COORD_W-1:0]        out_row;
    logic signed [uas_pkg::DATA_W-1:0]  advection_u;
    logic signed [uas_pkg::DATA_W-1:0]  advection_v;

    modport source (
        output valid, out_col, out_row, advection_u, advection_v,
        input  ready
    );
    modport sink (
        input  valid, out_col, out_row, advection_u, advection_v,
        output ready
    );
endinterface

// File: hdl/upwind_advection_stencil_2d.sv
// Registers in order: face, product, difference, part, term, sum, result.
// Throughput: one beat per cycle unless result.ready stalls; every stage has its
//   own valid bit, so bubbles close up and input is taken while a finished result waits.
// Reset (rst_n, async, active low): all stages empty, both reciprocal
//   spacings back to 1.0 (0x0001_0000).
`include "upwind_advection_stencil_2d_macros.svh"

module upwind_advection_stencil_2d #(
    parameter int FRAC_BITS  = uas_pkg::FRAC_BITS_DEF,
    parameter int COORD_BITS = uas_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [uas_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [uas_pkg::CFG_DATA_W-1:0]  cfg_data,
    uas_stencil_if.sink                     stencil,
    uas_result_if.source                    result
);
    import uas_pkg::*;

    // coordinates are echoed masked to COORD_BITS
    localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((32'd1 << COORD_BITS) - 32'd1);

    // Reciprocal spacings, unsigned Q(32-F).F. They must be written only while the pipeline
    // is empty (the block does not enforce this), so they are used directly by the scale stage.
    logic [CFG_DATA_W-1:0] inv_x_reg;
    logic [CFG_DATA_W-1:0] inv_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_x_reg <= INV_SPACING_RESET;
            inv_y_reg <= INV_SPACING_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_INV_SPACING_X: inv_x_reg <= cfg_data;
                CFG_INV_SPACING_Y: inv_y_reg <= cfg_data;
                default:           ;   // unused register slots
            endcase
        end
    end

    stencil_t in_data;
    face_t    face_data;
    flux_t    flux_data;
    result_t  res_data;
    logic     face_valid, face_ready;
    logic     flux_valid, flux_ready;

    always_comb
    begin
        in_data.col      = stencil.cell_col & COORD_MASK;
        in_data.row      = stencil.cell_row & COORD_MASK;
        in_data.u_center = stencil.u_center;
        in_data.u_east   = stencil.u_east;
        in_data.u_west   = stencil.u_west;
        in_data.u_north  = stencil.u_north;
        in_data.u_south  = stencil.u_south;
        in_data.v_center = stencil.v_center;
        in_data.v_east   = stencil.v_east;
        in_data.v_west   = stencil.v_west;
        in_data.v_north  = stencil.v_north;
        in_data.v_south  = stencil.v_south;
    end

    // stage 1: face averages, upwind picks
    uas_face u_face (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stencil.valid),
        .in_ready  (stencil.ready),
        .in_data   (in_data),
        .out_valid (face_valid),
        .out_ready (face_ready),
        .out_data  (face_data)
    );

    // stages 2-3: flux products and differences
    uas_flux u_flux (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (face_valid),
        .in_ready  (face_ready),
        .in_data   (face_data),
        .out_valid (flux_valid),
        .out_ready (flux_ready),
        .out_data  (flux_data)
    );

    // stages 4-7: spacing scale, sum, round half up, saturate; stage 7 is the
    // output register
    uas_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .inv_x     (inv_x_reg),
        .inv_y     (inv_y_reg),
        .in_valid  (flux_valid),
        .in_ready  (flux_ready),
        .in_data   (flux_data),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (res_data)
    );

    assign result.out_col     = res_data.col;
    assign result.out_row     = res_data.row;
    assign result.advection_u = res_data.adv_u;
    assign result.advection_v = res_data.adv_v;

    // back-pressure at the input can only come from a stalled result beat
    `UAS_ASSERT_IMP(a_stall_source, clk, rst_n, !stencil.ready, result.valid && !result.ready)
    // a taken result frees the whole chain
    `UAS_ASSERT_IMP(a_drain_ready, clk, rst_n, result.valid && result.ready, stencil.ready)
    // an accepted beat occupies stage 1 on the next cycle
    `UAS_ASSERT_NXT(a_enter_stage1, clk, rst_n, stencil.valid && stencil.ready, face_valid)

endmodule

// File: hdl/uas_face.sv
// Stage 1: face averages and upwind selection.
module uas_face (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  uas_pkg::stencil_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output uas_pkg::face_t     out_data
);
    import uas_pkg::*;

    // floor((a+b+1)/2), always fits in DATA_W bits
    function automatic logic [DATA_W-1:0] face_avg(input logic [DATA_W-1:0] a,
                                                   input logic [DATA_W-1:0] b);
        logic [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b} + (DATA_W+1)'(1);
        return s[DATA_W:1];
    endfunction

    // sign test on the exact sum; zero counts as non-negative
    function automatic logic face_nonneg(input logic [DATA_W-1:0] a,
                                         input logic [DATA_W-1:0] b);
        logic [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        return !s[DATA_W];
    endfunction

    logic  valid_reg;
    face_t data_reg;
    face_t data_next;
    logic  pos_e, pos_w, pos_n, pos_s;

    always_comb
    begin
        pos_e = face_nonneg(in_data.u_center, in_data.u_east);
        pos_w = face_nonneg(in_data.u_west,   in_data.u_center);
        pos_n = face_nonneg(in_data.v_center, in_data.v_north);
        pos_s = face_nonneg(in_data.v_south,  in_data.v_center);

        data_next.col = in_data.col;
        data_next.row = in_data.row;
        data_next.fe  = face_avg(in_data.u_center, in_data.u_east);
        data_next.fw  = face_avg(in_data.u_west,   in_data.u_center);
        data_next.fn  = face_avg(in_data.v_center, in_data.v_north);
        data_next.fs  = face_avg(in_data.v_south,  in_data.v_center);

        // high faces take the center when flow is positive, low faces the far side
        data_next.ux_e = pos_e ? in_data.u_center : in_data.u_east;
        data_next.ux_w = pos_w ? in_data.u_west   : in_data.u_center;
        data_next.uy_n = pos_n ? in_data.u_center : in_data.u_north;
        data_next.uy_s = pos_s ? in_data.u_south  : in_data.u_center;
        data_next.vx_e = pos_e ? in_data.v_center : in_data.v_east;
        data_next.vx_w = pos_w ? in_data.v_west   : in_data.v_center;
        data_next.vy_n = pos_n ? in_data.v_center : in_data.v_north;
        data_next.vy_s = pos_s ? in_data.v_south  : in_data.v_center;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
            data_reg <= data_next;
    end

endmodule

// File: hdl/uas_flux.sv
// Stages 2-3: eight 32x32 flux products, then the four flux differences.
module uas_flux (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  uas_pkg::face_t   in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output uas_pkg::flux_t   out_data
);
    import uas_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0]       col;
        logic [COORD_W-1:0]       row;
        logic signed [PROD_W-1:0] ux_e;
        logic signed [PROD_W-1:0] ux_w;
        logic signed [PROD_W-1:0] uy_n;
        logic signed [PROD_W-1:0] uy_s;
        logic signed [PROD_W-1:0] vx_e;
        logic signed [PROD_W-1:0] vx_w;
        logic signed [PROD_W-1:0] vy_n;
        logic signed [PROD_W-1:0] vy_s;
    } prod_t;

    logic  prod_valid_reg;
    prod_t prod_reg;
    prod_t prod_next;
    logic  prod_ready;

    logic  diff_valid_reg;
    flux_t diff_reg;
    flux_t diff_next;
    logic  diff_ready;

    always_comb
    begin
        prod_next.col  = in_data.col;
        prod_next.row  = in_data.row;
        prod_next.ux_e = $signed(in_data.fe) * $signed(in_data.ux_e);
        prod_next.ux_w = $signed(in_data.fw) * $signed(in_data.ux_w);
        prod_next.uy_n = $signed(in_data.fn) * $signed(in_data.uy_n);
        prod_next.uy_s = $signed(in_data.fs) * $signed(in_data.uy_s);
        prod_next.vx_e = $signed(in_data.fe) * $signed(in_data.vx_e);
        prod_next.vx_w = $signed(in_data.fw) * $signed(in_data.vx_w);
        prod_next.vy_n = $signed(in_data.fn) * $signed(in_data.vy_n);
        prod_next.vy_s = $signed(in_data.fs) * $signed(in_data.vy_s);
    end

    // difference of two 64-bit products cannot leave 64 bits
    always_comb
    begin
        diff_next.col = prod_reg.col;
        diff_next.row = prod_reg.row;
        diff_next.dux = $signed(prod_reg.ux_e) - $signed(prod_reg.ux_w);
        diff_next.duy = $signed(prod_reg.uy_n) - $signed(prod_reg.uy_s);
        diff_next.dvx = $signed(prod_reg.vx_e) - $signed(prod_reg.vx_w);
        diff_next.dvy = $signed(prod_reg.vy_n) - $signed(prod_reg.vy_s);
    end

    assign diff_ready = !diff_valid_reg || out_ready;
    assign prod_ready = !prod_valid_reg || diff_ready;
    assign in_ready   = prod_ready;
    assign out_valid  = diff_valid_reg;
    assign out_data   = diff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            diff_valid_reg <= 1'b0;
        end
        else
        begin
            if (prod_ready)
                prod_valid_reg <= in_valid;
            if (diff_ready)
                diff_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_ready)
            prod_reg <= prod_next;
        if (diff_ready)
            diff_reg <= diff_next;
    end

endmodule

// File: hdl/uas_scale.sv
// Stages 4-7: spacing multiply (split 64x32), term assembly, sum, round/saturate.
module uas_scale #(
    parameter int FRAC_BITS = uas_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [uas_pkg::CFG_DATA_W-1:0]     inv_x,
    input  logic [uas_pkg::CFG_DATA_W-1:0]     inv_y,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  uas_pkg::flux_t                     in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output uas_pkg::result_t                   out_data
);
    import uas_pkg::*;

    localparam int HALF_W  = PROD_W / 2;
    localparam int TERM_W  = PROD_W + CFG_DATA_W;
    localparam int ACC_W   = TERM_W + 1;
    localparam int RES_LSB = 2 * FRAC_BITS;
    localparam int RES_MSB = RES_LSB + DATA_W - 1;
    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (RES_LSB - 1);

    typedef struct packed {
        logic [PROD_W-1:0] lo;
        logic [PROD_W-1:0] hi;
    } pp_t;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        pp_t                ux;
        pp_t                uy;
        pp_t                vx;
        pp_t                vy;
    } part_t;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [TERM_W-1:0]  ux;
        logic [TERM_W-1:0]  uy;
        logic [TERM_W-1:0]  vx;
        logic [TERM_W-1:0]  vy;
    } term_t;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [ACC_W-1:0]   u;
        logic [ACC_W-1:0]   v;
    } acc_t;

    // lower half unsigned, upper half signed; both fit 64 bits
    function automatic pp_t split_mul(input logic [PROD_W-1:0]     d,
                                      input logic [CFG_DATA_W-1:0] r);
        logic signed [PROD_W:0] ph;
        pp_t                    p;
        p.lo = d[HALF_W-1:0] * r;
        ph   = $signed(d[PROD_W-1:HALF_W]) * $signed({1'b0, r});
        p.hi = ph[PROD_W-1:0];
        return p;
    endfunction

    function automatic logic [TERM_W-1:0] join_pp(input pp_t p);
        return {p.hi, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, p.lo};
    endfunction

    function automatic logic [DATA_W-1:0] round_sat(input logic [ACC_W-1:0] a);
        logic [DATA_W-1:0] r;
        if (a[ACC_W-1])
            r = (&a[ACC_W-1:RES_MSB]) ? a[RES_MSB:RES_LSB] : SAT_MIN;
        else
            r = (|a[ACC_W-1:RES_MSB]) ? SAT_MAX : a[RES_MSB:RES_LSB];
        return r;
    endfunction

    logic    part_valid_reg, term_valid_reg, acc_valid_reg, res_valid_reg;
    logic    part_ready, term_ready, acc_ready, res_ready;
    part_t   part_reg, part_next;
    term_t   term_reg, term_next;
    acc_t    acc_reg, acc_next;
    result_t res_reg, res_next;

    always_comb
    begin
        part_next.col = in_data.col;
        part_next.row = in_data.row;
        part_next.ux  = split_mul(in_data.dux, inv_x);
        part_next.uy  = split_mul(in_data.duy, inv_y);
        part_next.vx  = split_mul(in_data.dvx, inv_x);
        part_next.vy  = split_mul(in_data.dvy, inv_y);

        term_next.col = part_reg.col;
        term_next.row = part_reg.row;
        term_next.ux  = join_pp(part_reg.ux);
        term_next.uy  = join_pp(part_reg.uy);
        term_next.vx  = join_pp(part_reg.vx);
        term_next.vy  = join_pp(part_reg.vy);

        acc_next.col = term_reg.col;
        acc_next.row = term_reg.row;
        acc_next.u   = {term_reg.ux[TERM_W-1], term_reg.ux}
                     + {term_reg.uy[TERM_W-1], term_reg.uy} + HALF;
        acc_next.v   = {term_reg.vx[TERM_W-1], term_reg.vx}
                     + {term_reg.vy[TERM_W-1], term_reg.vy} + HALF;

        res_next.col   = acc_reg.col;
        res_next.row   = acc_reg.row;
        res_next.adv_u = round_sat(acc_reg.u);
        res_next.adv_v = round_sat(acc_reg.v);
    end

    assign res_ready  = !res_valid_reg  || out_ready;
    assign acc_ready  = !acc_valid_reg  || res_ready;
    assign term_ready = !term_valid_reg || acc_ready;
    assign part_ready = !part_valid_reg || term_ready;
    assign in_ready   = part_ready;
    assign out_valid  = res_valid_reg;
    assign out_data   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_valid_reg <= 1'b0;
            term_valid_reg <= 1'b0;
            acc_valid_reg  <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (part_ready)
                part_valid_reg <= in_valid;
            if (term_ready)
                term_valid_reg <= part_valid_reg;
            if (acc_ready)
                acc_valid_reg <= term_valid_reg;
            if (res_ready)
                res_valid_reg <= acc_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (part_ready)
            part_reg <= part_next;
        if (term_ready)
            term_reg <= term_next;
        if (acc_ready)
            acc_reg <= acc_next;
        if (res_ready)
            res_reg <= res_next;
    end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
    import uas_pkg::*;

    // Fixed-point format of the instance under test
    localparam int FRAC = FRAC_BITS_DEF;
    localparam int COORD = COORD_BITS_DEF;

    // Config indexes that map to no register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // Pipeline depth is 7; settle a little past it before touching config
    localparam int SETTLE_CYCLES = 12;
    // Cycles without any beat before the run is declared hung
    localparam int HANG_LIMIT = 4000;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    uas_stencil_if stencil_bus ();
    uas_result_if result_bus ();

    upwind_advection_stencil_2d dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stencil   (stencil_bus),
        .result    (result_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the two reciprocal spacings, updated as they are written
    logic [CFG_DATA_W-1:0] spacing_x_q = INV_SPACING_RESET;
    logic [CFG_DATA_W-1:0] spacing_y_q = INV_SPACING_RESET;

    // Predicted advection results, oldest first
    result_t pending_advection[$];

    int error_count = 0;
    int send_gap_pct = 0;    // chance per cycle that the sender holds off
    int stall_pct = 0;       // chance per cycle that the receiver deasserts ready
    int quiet_cycles = 0;

    // ------------------------------------------------------------------
    // Arithmetic model
    // ------------------------------------------------------------------

    // One axis: F_hi * up_hi - F_lo * up_lo, carried exactly.
    // Face velocity is floor((a+b+1)/2); upwind choice is taken on the
    // exact face sum, with zero counted as non-negative.
    function automatic logic signed [65:0] upwind_flux_diff(
        input logic signed [DATA_W-1:0] c,
        input logic signed [DATA_W-1:0] hi_nb,
        input logic signed [DATA_W-1:0] lo_nb,
        input logic signed [DATA_W-1:0] val_c,
        input logic signed [DATA_W-1:0] val_hi,
        input logic signed [DATA_W-1:0] val_lo
    );
        logic signed [33:0] sum_hi;
        logic signed [33:0] sum_lo;
        logic signed [33:0] face_hi;
        logic signed [33:0] face_lo;
        logic signed [DATA_W-1:0] up_hi;
        logic signed [DATA_W-1:0] up_lo;
        sum_hi = c + hi_nb;
        sum_lo = lo_nb + c;
        face_hi = (sum_hi + 34'sd1) >>> 1;
        face_lo = (sum_lo + 34'sd1) >>> 1;
        // east/north face: center is upwind for positive flow
        up_hi = (sum_hi >= 0) ? val_c : val_hi;
        // west/south face: far neighbor is upwind for positive flow
        up_lo = (sum_lo >= 0) ? val_lo : val_c;
        return face_hi * up_hi - face_lo * up_lo;
    endfunction

    // Scale by the spacings, round half up once, saturate to Q16.16
    function automatic logic signed [DATA_W-1:0] scale_round_sat(
        input logic signed [65:0] diff_x,
        input logic signed [65:0] diff_y
    );
        logic signed [127:0] acc;
        logic signed [127:0] scaled;
        acc = diff_x * $signed({1'b0, spacing_x_q}) + diff_y * $signed({1'b0, spacing_y_q});
        acc = acc + (128'sd1 <<< (2 * FRAC - 1));
        scaled = acc >>> (2 * FRAC);
        if (scaled > 128'sd2147483647)
            return SAT_MAX;
        if (scaled < -128'sd2147483648)
            return SAT_MIN;
        return scaled[DATA_W-1:0];
    endfunction

    function automatic result_t predict_advection(input stencil_t s);
        result_t r;
        logic signed [65:0] dux;
        logic signed [65:0] duy;
        logic signed [65:0] dvx;
        logic signed [65:0] dvy;
        // x faces are driven by u, y faces by v, in both equations
        dux = upwind_flux_diff(s.u_center, s.u_east, s.u_west,
                               s.u_center, s.u_east, s.u_west);
        duy = upwind_flux_diff(s.v_center, s.v_north, s.v_south,
                               s.u_center, s.u_north, s.u_south);
        dvx = upwind_flux_diff(s.u_center, s.u_east, s.u_west,
                               s.v_center, s.v_east, s.v_west);
        dvy = upwind_flux_diff(s.v_center, s.v_north, s.v_south,
                               s.v_center, s.v_north, s.v_south);
        r.col = s.col & COORD_W'((1 << COORD) - 1);
        r.row = s.row & COORD_W'((1 << COORD) - 1);
        r.adv_u = scale_round_sat(dux, duy);
        r.adv_v = scale_round_sat(dvx, dvy);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic stencil_t make_cell(
        input logic [COORD_W-1:0] col,
        input logic [COORD_W-1:0] row,
        input logic signed [DATA_W-1:0] uc, ue, uw, un, us,
        input logic signed [DATA_W-1:0] vc, ve, vw, vn, vs
    );
        stencil_t s;
        s.col = col;
        s.row = row;
        s.u_center = uc;
        s.u_east = ue;
        s.u_west = uw;
        s.u_north = un;
        s.u_south = us;
        s.v_center = vc;
        s.v_east = ve;
        s.v_west = vw;
        s.v_north = vn;
        s.v_south = vs;
        return s;
    endfunction

    function automatic logic signed [DATA_W-1:0] extreme_velocity();
        case ($urandom_range(0, 4))
            0: return SAT_MAX;
            1: return SAT_MIN;
            2: return 0;
            3: return 1;
            default: return -1;
        endcase
    endfunction

    // Mostly physical magnitudes (about +-16.0), now and then anything
    function automatic logic signed [DATA_W-1:0] pick_center();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return extreme_velocity();
            default: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
        endcase
    endfunction

    // Neighbors sit near the center; mirrored values give zero face sums
    function automatic logic signed [DATA_W-1:0] pick_neighbor(
        input logic signed [DATA_W-1:0] center
    );
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return extreme_velocity();
            2: return -center;
            3: return center;
            default: return center + (int'($urandom_range(0, 1 << 19)) - (1 << 18));
        endcase
    endfunction

    function automatic stencil_t random_cell();
        logic signed [DATA_W-1:0] uc;
        logic signed [DATA_W-1:0] vc;
        uc = pick_center();
        vc = pick_center();
        return make_cell(COORD_W'($urandom), COORD_W'($urandom),
                         uc, pick_neighbor(uc), pick_neighbor(uc),
                         pick_neighbor(uc), pick_neighbor(uc),
                         vc, pick_neighbor(vc), pick_neighbor(vc),
                         pick_neighbor(vc), pick_neighbor(vc));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_spacing();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return INV_SPACING_RESET;
            3: return $urandom;
            default: return $urandom_range(1, 32'h0004_0000);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver tasks; all are entered and left at a falling edge
    // ------------------------------------------------------------------

    // Offer one cell, wait for the beat, record what it should produce
    task automatic send_cell(input stencil_t s);
        while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            stencil_bus.valid <= 1'b0;
            @(negedge clk);
        end
        stencil_bus.cell_col <= s.col;
        stencil_bus.cell_row <= s.row;
        stencil_bus.u_center <= s.u_center;
        stencil_bus.u_east <= s.u_east;
        stencil_bus.u_west <= s.u_west;
        stencil_bus.u_north <= s.u_north;
        stencil_bus.u_south <= s.u_south;
        stencil_bus.v_center <= s.v_center;
        stencil_bus.v_east <= s.v_east;
        stencil_bus.v_west <= s.v_west;
        stencil_bus.v_north <= s.v_north;
        stencil_bus.v_south <= s.v_south;
        stencil_bus.valid <= 1'b1;
        @(posedge clk);
        while (!stencil_bus.ready)
            @(posedge clk);
        pending_advection.push_back(predict_advection(s));
        @(negedge clk);
    endtask

    // Stop offering and let the pipeline empty out
    task automatic drain_pipeline();
        stencil_bus.valid <= 1'b0;
        while (pending_advection.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register write; the caller makes sure the pipe is empty
    task automatic write_spacing(
        input logic [CFG_IDX_W-1:0] idx,
        input logic [CFG_DATA_W-1:0] value
    );
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == CFG_INV_SPACING_X)
            spacing_x_q = value;
        else if (idx == CFG_INV_SPACING_Y)
            spacing_y_q = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked cells: field extremes, every sign mix at the faces,
    // zero face sums, saturation both ways and rounding ties.
    task automatic test_directed();
        send_gap_pct = 0;
        stall_pct = 0;
        // reset spacings (1.0 each) are in force here
        send_cell(make_cell(12'd0, 12'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_cell(make_cell(12'hFFF, 12'hFFF, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX,
                            SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX));
        send_cell(make_cell(12'hAAA, 12'h555, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN,
                            SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN));
        // face sums of -1: both faces negative
        send_cell(make_cell(12'h555, 12'hAAA, SAT_MAX, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN,
                            SAT_MAX, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN));
        send_cell(make_cell(12'h001, 12'h800, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX,
                            SAT_MIN, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX));
        // every face sum exactly zero, which must count as non-negative
        send_cell(make_cell(12'd17, 12'd42, 32'sh0003_0000, -32'sh0003_0000, -32'sh0003_0000,
                            32'sh0001_8000, -32'sh0000_4000,
                            -32'sh0002_0000, 32'sh0000_C000, -32'sh0001_0000,
                            32'sh0002_0000, 32'sh0002_0000));
        // flow toward +x/+y, then toward -x/-y
        send_cell(make_cell(12'd100, 12'd200, 32'sh0002_0000, 32'sh0002_8000, 32'sh0001_8000,
                            32'sh0002_4000, 32'sh0001_C000,
                            32'sh0001_0000, 32'sh0001_4000, 32'sh0000_C000,
                            32'sh0001_2000, 32'sh0000_E000));
        send_cell(make_cell(12'd300, 12'd400, -32'sh0002_0000, -32'sh0002_8000,
                            -32'sh0001_8000, -32'sh0002_4000, -32'sh0001_C000,
                            -32'sh0001_0000, -32'sh0001_4000, -32'sh0000_C000,
                            -32'sh0001_2000, -32'sh0000_E000));
        // crossed flow: u one way, v the other
        send_cell(make_cell(12'd5, 12'd6, 32'sh0001_0000, 32'sh0001_1000, 32'sh0000_F000,
                            32'sh0000_8000, 32'sh0001_8000,
                            -32'sh0000_8000, -32'sh0000_4000, -32'sh0000_C000,
                            -32'sh0000_A000, -32'sh0000_6000));
        send_cell(make_cell(12'd7, 12'd8, -32'sh0001_0000, 32'sh0000_4000, -32'sh0003_0000,
                            -32'sh0000_8000, 32'sh0001_8000,
                            32'sh0000_8000, -32'sh0000_4000, 32'sh0002_0000,
                            -32'sh0000_2000, 32'sh0000_6000));
        // alternating bit patterns
        send_cell(make_cell(12'hAAA, 12'h555, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                            32'shAAAA_AAAA, 32'sh5555_5555,
                            32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                            32'sh5555_5555, 32'shAAAA_AAAA));
        drain_pipeline();

        // largest spacings: push the sum past both saturation limits
        write_spacing(CFG_INV_SPACING_X, '1);
        write_spacing(CFG_INV_SPACING_Y, '1);
        send_cell(make_cell(12'd1, 12'd1, SAT_MAX, SAT_MAX, SAT_MIN, 0, 0,
                            0, 0, 0, 0, 0));
        send_cell(make_cell(12'd2, 12'd2, SAT_MAX, SAT_MIN, SAT_MAX, 0, 0,
                            0, 0, 0, 0, 0));
        send_cell(make_cell(12'd3, 12'd3, 32'sh0000_0001, 32'sh0000_0001, 0, 0, 0,
                            0, 0, 0, 0, 0));
        drain_pipeline();

        // tiny x spacing, no y term: exact half-LSB ties, positive and negative
        write_spacing(CFG_INV_SPACING_X, 32'd2);
        write_spacing(CFG_INV_SPACING_Y, '0);
        send_cell(make_cell(12'd9, 12'd9, 32'sh0000_8000, 32'sh0000_8000, 0, 0, 0,
                            0, 0, 0, 0, 0));
        send_cell(make_cell(12'd10, 12'd10, 32'sh0000_8000, -32'sh0000_8000, 32'sh0000_8000,
                            0, 0, 0, 0, 0, 0, 0));
        send_cell(make_cell(12'd11, 12'd11, 32'sh0000_8000, -32'sh0000_8000, 32'sh0000_8000,
                            32'sh1234_5678, -32'sh0765_4321, 0, 0, 0, 0, 0));
        drain_pipeline();
    endtask

    // Spacing corners, each with a short burst of random cells
    task automatic test_spacing_extremes();
        logic [CFG_DATA_W-1:0] corner_x[5];
        logic [CFG_DATA_W-1:0] corner_y[5];
        corner_x = '{32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1};
        corner_y = '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd1};
        send_gap_pct = 18;
        stall_pct = 18;
        for (int k = 0; k < 5; k++)
        begin
            write_spacing(CFG_INV_SPACING_X, corner_x[k]);
            write_spacing(CFG_INV_SPACING_Y, corner_y[k]);
            // writes to unused indexes must leave both spacings alone
            write_spacing(CFG_SPARE_2, $urandom);
            write_spacing(CFG_SPARE_3, $urandom);
            repeat (16) send_cell(random_cell());
            drain_pipeline();
        end
    endtask

    // Long random run under one idling mix, new spacings every so often
    task automatic test_random_traffic(
        input int gap_pct,
        input int stall,
        input int n_cells,
        input bit pause_midway
    );
        send_gap_pct = gap_pct;
        stall_pct = stall;
        for (int k = 0; k < n_cells; k++)
        begin
            if (k % 35 == 0)
            begin
                drain_pipeline();
                write_spacing(CFG_INV_SPACING_X, pick_spacing());
                write_spacing(CFG_INV_SPACING_Y, pick_spacing());
            end
            else if (pause_midway && k == n_cells / 2 + 3)
            begin
                // hold the input off until every result is back, then resume
                drain_pipeline();
            end
            send_cell(random_cell());
        end
        drain_pipeline();
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    always @(negedge clk)
        result_bus.ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            error_count++;
        end
    endtask

    // Every result beat is matched against the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_advection.size() == 0)
            begin
                $error("unexpected result beat: col %h row %h",
                       result_bus.out_col, result_bus.out_row);
                error_count++;
            end
            else
            begin
                want = pending_advection.pop_front();
                check_field("out_col", 32'(want.col), 32'(result_bus.out_col));
                check_field("out_row", 32'(want.row), 32'(result_bus.out_row));
                check_field("advection_u", want.adv_u, result_bus.advection_u);
                check_field("advection_v", want.adv_v, result_bus.advection_v);
            end
        end
    end

    // Hang detector: any beat on either side restarts the count
    always @(posedge clk)
    begin
        if ((stencil_bus.valid && stencil_bus.ready) || (result_bus.valid && result_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles, %0d results outstanding",
                     HANG_LIMIT, pending_advection.size());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_INV_SPACING_X;
        cfg_data <= '0;
        stencil_bus.valid <= 1'b0;
        stencil_bus.cell_col <= '0;
        stencil_bus.cell_row <= '0;
        stencil_bus.u_center <= '0;
        stencil_bus.u_east <= '0;
        stencil_bus.u_west <= '0;
        stencil_bus.u_north <= '0;
        stencil_bus.u_south <= '0;
        stencil_bus.v_center <= '0;
        stencil_bus.v_east <= '0;
        stencil_bus.v_west <= '0;
        stencil_bus.v_north <= '0;
        stencil_bus.v_south <= '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_spacing_extremes();
        test_random_traffic(0, 0, 105, 1'b0);
        test_random_traffic(56, 0, 105, 1'b1);
        test_random_traffic(0, 56, 105, 1'b0);
        test_random_traffic(18, 18, 105, 1'b0);

        drain_pipeline();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (pending_advection.size() != 0)
        begin
            $error("%0d results never arrived", pending_advection.size());
            error_count++;
        end
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
